[src/tkh_pkg.sv]
// Shared types and constants for the top-K min-heap block.
// Used by tkh_core and top_k_min_heap_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tkh_pkg;

    // Built capacity of the heap storage.
    localparam int DEF_CAPACITY = 64;

    // Field widths.
    localparam int CFG_W   = 7;
    localparam int MODE_W  = 2;
    localparam int VAL_W   = 32;
    localparam int TAG_W   = 24;
    localparam int CNT_W   = 7;

    // Capacity register value after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Operation codes; any other code clears the heap.
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_EVICTED   = 3'd1,
        ST_DISCARDED = 3'd2,
        ST_POPPED    = 3'd3,
        ST_POP_EMPTY = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

    // Engine sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT_CHK,
        S_DN_RD,
        S_DN_CMP,
        S_UP_RD,
        S_UP_CMP,
        S_DONE
    } t_state;

    // One stored heap entry.
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [TAG_W-1:0]        tag;
    } t_entry;

    // Request from the input channel to the engine.
    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic signed [VAL_W-1:0] value;
        logic [TAG_W-1:0]        tag;
    } t_req;

    // Result from the engine to the output register.
    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] value;
        logic [TAG_W-1:0]        tag;
        logic [CNT_W-1:0]        entry_count;
    } t_rsp;

endpackage

`default_nettype wire

[src/top_k_min_heap_top.sv]
// Top level of the top-K min-heap: stream ports, capacity register and output register.
// Depends on tkh_pkg and tkh_core.
//
// Usage:
// - Input channel s_axis: one operation per transfer. tuser holds the mode
//   (insert, pop minimum, clear; any other code clears). tdata holds value and tag.
// - Output channel m_axis: exactly one result per input transfer, in order.
//   tuser holds the status, tdata the evicted or popped pair and the entry count.
// - i_cfg_wr_en / i_cfg_wr_data write the number of entries kept. Zero acts as one,
//   values above the built capacity act as the capacity. Write only while idle.
// - Clear, pop on empty and discard touch no heap level; an insert sifts up, a pop
//   sifts down, and an eviction sifts down and then up, with one memory read and
//   one write-back per heap level.
// - One item at a time: the next item is taken once the engine hands its result to
//   the output register.
// - Reset empties the heap and sets the capacity register to 64; no clearing pass.
// - When the receiver stalls, the result holds in the output register and the
//   engine holds the following result until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module top_k_min_heap_top
    import tkh_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [55:0]      s_axis_tdata,   // value[31:0], tag[55:32]
    input  wire logic [1:0]       s_axis_tuser,   // mode[1:0]
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [63:0]           m_axis_tdata,   // out_value[31:0], out_tag[55:32],
                                                  // entry_count[62:56], zero[63]
    output logic [2:0]            m_axis_tuser    // status[2:0]
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CFG_W-1:0] r_cap_cfg;
    logic [CW-1:0]    cap_eff;
    t_req             req;
    t_rsp             rsp;
    logic             rsp_valid, rsp_take;
    logic             r_m_valid;
    logic [63:0]      r_m_data;
    logic [2:0]       r_m_user;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap_cfg <= i_cfg_wr_data;
        end
    end

    // Clamp the written capacity into the built range.
    always_comb begin
        if (r_cap_cfg == '0) begin
            cap_eff = CW'(1);
        end else if (32'(r_cap_cfg) > CAPACITY) begin
            cap_eff = CW'(CAPACITY);
        end else begin
            cap_eff = CW'(r_cap_cfg);
        end
    end

    // Unpack the input transfer.
    assign req.mode  = s_axis_tuser;
    assign req.value = s_axis_tdata[31:0];
    assign req.tag   = s_axis_tdata[55:32];

    tkh_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (cap_eff),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_take),
        .o_rsp       (rsp)
    );

    // Output register: loads when empty or when its result is being taken.
    assign rsp_take = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (rsp_take) begin
            r_m_valid <= rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_take && rsp_valid) begin
            r_m_data <= {1'b0, rsp.entry_count, rsp.tag, rsp.value};
            r_m_user <= rsp.status;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

`default_nettype wire

[src/tkh_core.sv]
// Heap engine: entry memory plus the sequencer for root check, sift-down and sift-up.
// Depends on tkh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tkh_core
    import tkh_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [CW-1:0] i_capacity,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire t_req          i_req,
    output logic               o_rsp_valid,
    input  wire logic          i_rsp_ready,
    output t_rsp               o_rsp
);

    localparam int AW = $clog2(CAPACITY);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_n, n_n;
    logic [CW-1:0]  r_idx, n_idx;
    logic [MODE_W-1:0] r_mode, n_mode;
    t_status        r_status, n_status;
    t_entry         r_x, n_x;
    t_entry         r_new, n_new;
    t_entry         r_out, n_out;

    // Entry memory with two registered read ports and one write port.
    t_entry         r_mem [CAPACITY];
    t_entry         r_rd_a, r_rd_b;
    logic [AW-1:0]  rd_addr_a, rd_addr_b, wr_addr;
    logic           wr_en;
    t_entry         wr_data;

    // Index arithmetic for the current hole position.
    logic [CW:0]    child_l, child_r;
    logic [CW-1:0]  parent, last_idx;
    logic           l_ok, r_ok, l_lt, r_lt, up_lt, root_lt, is_insert, heap_full;
    t_entry         best_lr;

    assign child_l   = {r_idx, 1'b1};
    assign child_r   = {r_idx, 1'b0} + (CW+1)'(2);
    assign parent    = (r_idx - CW'(1)) >> 1;
    assign last_idx  = r_count - CW'(1);
    assign l_ok      = child_l < {1'b0, r_n};
    assign r_ok      = child_r < {1'b0, r_n};
    assign l_lt      = l_ok && (r_rd_a.value < r_x.value);
    assign best_lr   = l_lt ? r_rd_a : r_x;
    assign r_lt      = r_ok && (r_rd_b.value < best_lr.value);
    assign up_lt     = r_x.value < r_rd_a.value;
    assign root_lt   = r_rd_a.value < r_new.value;
    assign is_insert = (r_mode == MODE_INSERT);
    assign heap_full = (r_count >= i_capacity);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    if (i_req.mode == MODE_INSERT) begin
                        n_state = heap_full ? S_ROOT_CHK : S_UP_RD;
                    end else if (i_req.mode == MODE_POP) begin
                        n_state = (r_count == '0) ? S_DONE : S_ROOT_CHK;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ROOT_CHK: begin
                n_state = (is_insert && !root_lt) ? S_DONE : S_DN_RD;
            end
            S_DN_RD: n_state = S_DN_CMP;
            S_DN_CMP: begin
                if (l_lt || r_lt) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = is_insert ? S_UP_RD : S_DONE;
                end
            end
            S_UP_RD: n_state = (r_idx == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP: n_state = up_lt ? S_UP_RD : S_DONE;
            S_DONE: n_state = i_rsp_ready ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath, memory control and register next values.
    always_comb begin
        n_count   = r_count;
        n_n       = r_n;
        n_idx     = r_idx;
        n_mode    = r_mode;
        n_status  = r_status;
        n_x       = r_x;
        n_new     = r_new;
        n_out     = r_out;
        rd_addr_a = '0;
        rd_addr_b = last_idx[AW-1:0];
        wr_en     = 1'b0;
        wr_addr   = r_idx[AW-1:0];
        wr_data   = r_x;
        case (r_state)
            S_IDLE: begin
                // Root and last entry are read every idle cycle for the next item.
                if (i_req_valid) begin
                    n_mode      = i_req.mode;
                    n_new.value = i_req.value;
                    n_new.tag   = i_req.tag;
                    n_out       = '0;
                    if (i_req.mode == MODE_INSERT) begin
                        if (!heap_full) begin
                            n_status    = ST_INSERTED;
                            n_idx       = r_count;
                            n_n         = r_count;
                            n_x.value   = i_req.value;
                            n_x.tag     = i_req.tag;
                        end
                    end else if (i_req.mode == MODE_POP) begin
                        n_status = ST_POP_EMPTY;
                    end else begin
                        n_status = ST_CLEARED;
                        n_count  = '0;
                    end
                end
            end
            S_ROOT_CHK: begin
                if (is_insert && !root_lt) begin
                    n_status = ST_DISCARDED;
                end else begin
                    n_status = is_insert ? ST_EVICTED : ST_POPPED;
                    n_out    = r_rd_a;
                    n_n      = last_idx;
                    n_x      = r_rd_b;
                    n_idx    = '0;
                end
            end
            S_DN_RD: begin
                rd_addr_a = child_l[AW-1:0];
                rd_addr_b = child_r[AW-1:0];
            end
            S_DN_CMP: begin
                // Move the smaller child into the hole, or settle the moving entry.
                wr_en = 1'b1;
                if (r_lt) begin
                    wr_data = r_rd_b;
                    n_idx   = child_r[CW-1:0];
                end else if (l_lt) begin
                    wr_data = r_rd_a;
                    n_idx   = child_l[CW-1:0];
                end else begin
                    wr_data = r_x;
                    if (is_insert) begin
                        n_idx = r_n;
                        n_x   = r_new;
                    end else begin
                        n_count = r_n;
                    end
                end
            end
            S_UP_RD: begin
                rd_addr_a = parent[AW-1:0];
                if (r_idx == '0) begin
                    wr_en   = 1'b1;
                    wr_data = r_x;
                    n_count = r_n + CW'(1);
                end
            end
            S_UP_CMP: begin
                // Pull a larger parent down into the hole, or settle the new entry.
                wr_en = 1'b1;
                if (up_lt) begin
                    wr_data = r_rd_a;
                    n_idx   = parent;
                end else begin
                    wr_data = r_x;
                    n_count = r_n + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_mode   <= n_mode;
        r_status <= n_status;
        r_x      <= n_x;
        r_new    <= n_new;
        r_out    <= n_out;
    end

    // Entry memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // Handshake and result.
    assign o_req_ready       = (r_state == S_IDLE);
    assign o_rsp_valid       = (r_state == S_DONE);
    assign o_rsp.status      = r_status;
    assign o_rsp.value       = r_out.value;
    assign o_rsp.tag         = r_out.tag;
    assign o_rsp.entry_count = CNT_W'(r_count);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("entry count exceeds the built capacity");

    a_down_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_RD || r_state == S_DN_CMP) |-> r_idx <= r_n)
        else $error("sift-down hole lies beyond the heap");

    a_up_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_RD || r_state == S_UP_CMP) |-> r_idx <= r_n)
        else $error("sift-up hole lies beyond the heap");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == ST_POP_EMPTY) |->
            (o_rsp.entry_count == '0 && o_rsp.value == '0 && o_rsp.tag == '0))
        else $error("pop on empty heap reports data");
`endif

endmodule

`default_nettype wire
